// ----- rtl/lzwbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LZW compressor package
// Shared code types, dictionary command struct and fixed code constants.
// ----------------------------------------------------------------------------
package lzwbc_pkg;

	localparam int CODE_W  = 12;
	localparam int BYTE_W  = 8;
	localparam int LIMIT_W = 13;

	typedef logic [CODE_W-1:0]  code_t;
	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [LIMIT_W-1:0] limit_t;

	// Codes below this value stand for single bytes.
	localparam code_t  FIRST_CODE     = code_t'(256);
	localparam limit_t FIRST_CODE_LIM = limit_t'(256);
	// Size of the code space that the code field can carry.
	localparam limit_t CODE_SPACE     = limit_t'(4096);

	// Requests from the sequencer to the dictionary.
	typedef struct packed {
		logic  rd_en;
		code_t rd_code;
		logic  wr_en;
		code_t wr_code;
		code_t wr_prefix;
		byte_t wr_byte;
	} dict_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/lzwbc_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte input channel
// Valid/ready channel carrying one uncompressed byte and its last flag.
// ----------------------------------------------------------------------------
interface lzwbc_in_if;
	logic                valid;
	logic                ready;
	lzwbc_pkg::byte_t    data_byte;
	logic                last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/lzwbc_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Code output channel
// Valid/ready channel carrying one emitted code and its final flag.
// ----------------------------------------------------------------------------
interface lzwbc_out_if;
	logic                valid;
	logic                ready;
	lzwbc_pkg::code_t    code;
	logic                final_code;

	modport source (output valid, output code, output final_code, input ready);
	modport sink   (input valid, input code, input final_code, output ready);
endinterface
`default_nettype wire

// ----- rtl/lzwbc_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying the code limit register value.
// ----------------------------------------------------------------------------
interface lzwbc_cfg_if;
	logic                valid;
	logic                ready;
	lzwbc_pkg::limit_t   code_limit;

	modport source (output valid, output code_limit, input ready);
	modport sink   (input valid, input code_limit, output ready);
endinterface
`default_nettype wire

// ----- rtl/lzw_byte_compressor.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LZW byte compressor
// Compresses byte strings into 12-bit LZW codes with a searchable dictionary.
// ----------------------------------------------------------------------------
// Usage: bytes arrive on the src channel, one per transfer, with last_byte
// set on the final byte of a string. Codes leave on the snk channel; the last
// code of a string carries final_code. The cfg channel writes code_limit,
// which caps the code values the dictionary hands out; it is always ready and
// should only be written while the block is idle.
// Search: each byte after the first of a string is searched against the
// dictionary one entry at a time, reading the entry memory (lookup) and
// comparing the pair (compare). On a miss the prefix code is sent and,
// while below the limit, the new entry is written; the final code leaves in
// the closing (finish) step. src is ready only while idle, so a new byte is
// taken only once the last one is through. The memory read port and the
// single pair comparator set the search speed.
// Reset: the prefix is empty, the dictionary is logically empty (no entry is
// searched until written) and code_limit returns to 4096.
// Stalls: an output register holds one code; if the receiver stalls while a
// second code must be sent, the sequencer waits and src stays not ready.
// ----------------------------------------------------------------------------
module lzw_byte_compressor #(
	parameter int DICT_SIZE = 4096
) (
	input  wire         clk,
	input  wire         arst_n,
	lzwbc_in_if.sink    src,
	lzwbc_out_if.source snk,
	lzwbc_cfg_if.sink   cfg
);
	import lzwbc_pkg::*;

	// Only the first 4096 codes fit the code field, so the memory stops there.
	localparam int     MEM_DEPTH = (DICT_SIZE < 4096) ? DICT_SIZE : 4096;
	localparam limit_t LIM_MAX   = limit_t'(MEM_DEPTH);

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_LOOKUP  = 5'b00010,
		ST_COMPARE = 5'b00100,
		ST_MISS    = 5'b01000,
		ST_FINISH  = 5'b10000
	} state_t;

	state_t    state_q;
	limit_t    code_limit_q;
	limit_t    next_code_q;
	code_t     prefix_q;
	logic      prefix_valid_q;
	code_t     srch_q;
	byte_t     byte_q;
	logic      last_q;
	logic      out_valid_q;
	code_t     out_code_q;
	logic      out_final_q;

	dict_cmd_t dict_cmd;
	logic      match;
	limit_t    eff_limit;
	logic      can_add;
	logic      out_free;
	logic      out_load;

	// Configuration register.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_limit_q <= CODE_SPACE;
		end else if (cfg.valid) begin
			code_limit_q <= cfg.code_limit;
		end
	end

	// New entries are added only below the smaller of code_limit and the
	// memory depth.
	assign eff_limit = (code_limit_q > LIM_MAX) ? LIM_MAX : code_limit_q;
	assign can_add   = (next_code_q < eff_limit);

	// The output register can take a new code when empty or being drained.
	assign out_free  = !out_valid_q || snk.ready;
	assign src.ready = (state_q == ST_IDLE);

	// Both emit points send the current prefix; only the final one flags it.
	assign out_load = out_free && ((state_q == ST_MISS) ||
		((state_q == ST_FINISH) && last_q));

	// Dictionary requests: read the entry under search, write on a miss.
	always_comb begin
		dict_cmd.rd_en     = (state_q == ST_LOOKUP);
		dict_cmd.rd_code   = srch_q;
		dict_cmd.wr_en     = (state_q == ST_MISS) && out_free && can_add;
		dict_cmd.wr_code   = next_code_q[CODE_W-1:0];
		dict_cmd.wr_prefix = prefix_q;
		dict_cmd.wr_byte   = byte_q;
	end

	lzwbc_dict #(
		.DEPTH(MEM_DEPTH)
	) u_dict (
		.clk       (clk),
		.cmd       (dict_cmd),
		.key_prefix(prefix_q),
		.key_byte  (byte_q),
		.match     (match)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			next_code_q    <= FIRST_CODE_LIM;
			prefix_q       <= '0;
			prefix_valid_q <= 1'b0;
			srch_q         <= FIRST_CODE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (src.valid) begin
						if (!prefix_valid_q) begin
							// First byte of a string just starts the prefix.
							prefix_q       <= {{(CODE_W-BYTE_W){1'b0}}, src.data_byte};
							prefix_valid_q <= 1'b1;
							state_q        <= ST_FINISH;
						end else if (next_code_q == FIRST_CODE_LIM) begin
							// Empty dictionary: nothing to search.
							state_q <= ST_MISS;
						end else begin
							srch_q  <= FIRST_CODE;
							state_q <= ST_LOOKUP;
						end
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_COMPARE;
				end
				ST_COMPARE: begin
					if (match) begin
						prefix_q <= srch_q;
						state_q  <= ST_FINISH;
					end else if ((limit_t'(srch_q) + limit_t'(1)) == next_code_q) begin
						state_q <= ST_MISS;
					end else begin
						srch_q  <= srch_q + code_t'(1);
						state_q <= ST_LOOKUP;
					end
				end
				ST_MISS: begin
					if (out_free) begin
						prefix_q <= {{(CODE_W-BYTE_W){1'b0}}, byte_q};
						if (can_add) begin
							next_code_q <= next_code_q + limit_t'(1);
						end
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						// End of string: start over with an empty dictionary.
						prefix_q       <= '0;
						prefix_valid_q <= 1'b0;
						next_code_q    <= FIRST_CODE_LIM;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Input byte capture.
	always_ff @(posedge clk) begin
		if (src.valid && src.ready) begin
			byte_q <= src.data_byte;
			last_q <= src.last_byte;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (snk.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_code_q  <= prefix_q;
			out_final_q <= (state_q == ST_FINISH);
		end
	end

	assign snk.valid      = out_valid_q;
	assign snk.code       = out_code_q;
	assign snk.final_code = out_final_q;

endmodule
`default_nettype wire

// ----- rtl/lzwbc_dict.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LZW dictionary
// Entry memory of (prefix, byte) pairs with a registered read port and the
// shared pair comparator used by the search.
// ----------------------------------------------------------------------------
module lzwbc_dict #(
	parameter int DEPTH = 4096
) (
	input  wire                        clk,
	input  wire lzwbc_pkg::dict_cmd_t  cmd,
	input  wire lzwbc_pkg::code_t      key_prefix,
	input  wire lzwbc_pkg::byte_t      key_byte,
	output logic                       match
);
	import lzwbc_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int EW = CODE_W + BYTE_W;

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_code[AW-1:0]] <= {cmd.wr_prefix, cmd.wr_byte};
		end
		if (cmd.rd_en) begin
			rd_q <= mem[cmd.rd_code[AW-1:0]];
		end
	end

	assign match = (rd_q == {key_prefix, key_byte});

endmodule
`default_nettype wire
